[hdl/uesc_pkg.sv]
`timescale 1ns / 1ps

package uesc_pkg;

   localparam int FIFO_DEPTH = 4;

   localparam logic [3:0] PHASE_IDLE        = 4'd0;
   localparam logic [3:0] PHASE_LEAD_FIRST  = 4'd2;
   localparam logic [3:0] PHASE_LEAD_LAST   = 4'd5;
   localparam logic [3:0] PHASE_SURR_GAP    = 4'd6;
   localparam logic [3:0] PHASE_TRAIL_FIRST = 4'd8;
   localparam logic [3:0] PHASE_TRAIL_LAST  = 4'd11;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_of_item;
      logic       end_of_string;
   } rsp_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic            marker;
      logic            last;
   } burst_type;

   typedef struct packed {
      logic      write;
      burst_type burst;
   } burst_wr_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      burst_type head;
   } fifo_status_type;

endpackage

[hdl/unicode_escape_to_utf8_top.sv]
`timescale 1ns / 1ps
// an item's first result is queued as a burst, then loaded into the rsp_ register
// throughput: one byte in per cycle unless req_full; one result out per cycle
// while rsp_pop keeps up; an item's k results occupy the back end in turn; a queue of
// FIFO_DEPTH bursts between front and back absorbs that, req_full rises when it fills
// reset: synchronous, clears the escape state, the burst queue and the output valid flag

module unicode_escape_to_utf8_top #(
   parameter int FIFO_DEPTH = uesc_pkg::FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  uesc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output uesc_pkg::rsp_type rsp_data
);

   uesc_pkg::burst_wr_type    burst_wr;
   uesc_pkg::fifo_status_type status;
   logic                      rd_en;
   logic                      accept;

   assign req_full = status.full;
   assign accept   = req_push && !status.full;

   uesc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .burst_wr (burst_wr)
   );

   uesc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .burst_wr (burst_wr),
      .rd_en    (rd_en),
      .status   (status)
   );

   uesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .rd_en     (rd_en),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/uesc_front.sv]
`timescale 1ns / 1ps

module uesc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  uesc_pkg::req_type     req_data,
   output uesc_pkg::burst_wr_type burst_wr
);

   localparam logic [15:0] SURR_LOW     = 16'hD800;
   localparam logic [15:0] SURR_HIGH    = 16'hDFFF;
   localparam logic [15:0] LEAD_HIGH    = 16'hDBFF;
   localparam logic [15:0] TRAIL_LOW    = 16'hDC00;
   localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [20:0] PLANE_OFFSET = 21'h10000;

   logic        pend_ff, pend_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] lead_ff, lead_in;
   logic [15:0] trail_ff, trail_in;
   logic        stop_ff, stop_in;

   logic [3:0][7:0] bytes;
   logic [2:0]      n;
   logic            marker;
   logic            in_esc, is_lead, take, first, sbase, stopd;
   logic [15:0]     base, nw;
   logic [4:0]      hv;
   logic [20:0]     u;
   logic [7:0]      b;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   always_comb begin
      b        = req_data.in_byte;
      pend_in  = pend_ff;
      phase_in = uesc_pkg::PHASE_IDLE;
      lead_in  = lead_ff;
      trail_in = trail_ff;
      stop_in  = stop_ff;
      bytes    = '0;
      n        = 3'd0;
      marker   = 1'b0;
      hv       = hex_value(b);
      in_esc   = (phase_ff >= uesc_pkg::PHASE_LEAD_FIRST) &&
                 (phase_ff <= uesc_pkg::PHASE_TRAIL_LAST);
      is_lead  = phase_ff <= uesc_pkg::PHASE_LEAD_LAST;
      take     = is_lead || (phase_ff >= uesc_pkg::PHASE_TRAIL_FIRST);
      first    = (phase_ff == uesc_pkg::PHASE_LEAD_FIRST) ||
                 (phase_ff == uesc_pkg::PHASE_TRAIL_FIRST);
      base     = first ? 16'd0 : (is_lead ? lead_ff : trail_ff);
      sbase    = first ? 1'b0 : stop_ff;
      if (!sbase && hv[4]) begin
         nw    = {base[11:0], hv[3:0]};
         stopd = 1'b0;
      end else begin
         nw    = base;
         stopd = 1'b1;
      end
      u = {1'b0, lead_ff[9:0], 10'd0} + {11'd0, nw[9:0]} + PLANE_OFFSET;

      if (in_esc) begin
         if (take) begin
            stop_in = stopd;
            if (is_lead) begin
               lead_in = nw;
            end else begin
               trail_in = nw;
            end
         end
         if (phase_ff == uesc_pkg::PHASE_LEAD_LAST) begin
            if (lead_in < SURR_LOW || lead_in > SURR_HIGH) begin
               if (lead_in == 16'd0) begin
                  n = 3'd0;
               end else if (lead_in <= ONE_BYTE_MAX) begin
                  bytes[0] = lead_in[7:0];
                  n        = 3'd1;
               end else if (lead_in <= TWO_BYTE_MAX) begin
                  bytes[0] = {3'b110, lead_in[10:6]};
                  bytes[1] = {2'b10, lead_in[5:0]};
                  n        = 3'd2;
               end else begin
                  bytes[0] = {4'b1110, lead_in[15:12]};
                  bytes[1] = {2'b10, lead_in[11:6]};
                  bytes[2] = {2'b10, lead_in[5:0]};
                  n        = 3'd3;
               end
            end else begin
               phase_in = uesc_pkg::PHASE_SURR_GAP;
            end
         end else if (phase_ff == uesc_pkg::PHASE_TRAIL_LAST) begin
            if (lead_ff <= LEAD_HIGH && trail_in >= TRAIL_LOW && trail_in <= SURR_HIGH) begin
               bytes[0] = {5'b11110, u[20:18]};
               bytes[1] = {2'b10, u[17:12]};
               bytes[2] = {2'b10, u[11:6]};
               bytes[3] = {2'b10, u[5:0]};
               n        = 3'd4;
            end
         end else begin
            phase_in = phase_ff + 4'd1;
         end
      end else if (pend_ff) begin
         pend_in = 1'b0;
         if (b == uesc_pkg::CHAR_LOWER_U) begin
            phase_in = uesc_pkg::PHASE_LEAD_FIRST;
         end else begin
            bytes[0] = uesc_pkg::CHAR_BACKSLASH;
            n        = 3'd1;
            if (b == uesc_pkg::CHAR_BACKSLASH) begin
               pend_in = 1'b1;
            end else begin
               bytes[1] = b;
               n        = 3'd2;
            end
         end
      end else if (b == uesc_pkg::CHAR_BACKSLASH) begin
         pend_in = 1'b1;
      end else begin
         bytes[0] = b;
         n        = 3'd1;
      end

      if (req_data.last_in) begin
         if (pend_in) begin
            bytes[n[1:0]] = uesc_pkg::CHAR_BACKSLASH;
            n             = n + 3'd1;
         end
         pend_in  = 1'b0;
         phase_in = uesc_pkg::PHASE_IDLE;
         lead_in  = '0;
         trail_in = '0;
         stop_in  = 1'b0;
         if (n == 3'd0) begin
            marker = 1'b1;
            n      = 3'd1;
         end
      end

      burst_wr.write        = accept && (n != 3'd0);
      burst_wr.burst.data   = bytes;
      burst_wr.burst.count  = n;
      burst_wr.burst.marker = marker;
      burst_wr.burst.last   = req_data.last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         phase_ff <= uesc_pkg::PHASE_IDLE;
         lead_ff  <= '0;
         trail_ff <= '0;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         lead_ff  <= lead_in;
         trail_ff <= trail_in;
         stop_ff  <= stop_in;
      end
   end

   // phase never sits on the backslash slot and never runs past the trail
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != 4'd1 && phase_ff <= uesc_pkg::PHASE_TRAIL_LAST)
      else $error("escape phase out of range");

endmodule

[hdl/uesc_fifo.sv]
`timescale 1ns / 1ps

module uesc_fifo #(
   parameter int DEPTH = uesc_pkg::FIFO_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  uesc_pkg::burst_wr_type    burst_wr,
   input  logic                      rd_en,
   output uesc_pkg::fifo_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   uesc_pkg::burst_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          wr_en;

   assign wr_en        = burst_wr.write;
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CW'(DEPTH);
   assign status.head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= burst_wr.burst;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(wr_en && status.full))
      else $error("burst queue overflow");

   assert property (@(posedge clock) disable iff (reset) !(rd_en && status.empty))
      else $error("burst queue underflow");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("burst queue count out of range");

endmodule

[hdl/uesc_back.sv]
`timescale 1ns / 1ps

module uesc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  uesc_pkg::fifo_status_type status,
   output logic                      rd_en,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output uesc_pkg::rsp_type         rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   uesc_pkg::rsp_type rsp_ff, rsp_in;
   logic              load, last_k;

   always_comb begin
      load   = !status.empty && (!valid_ff || rsp_pop);
      last_k = {1'b0, idx_ff} == (status.head.count - 3'd1);

      rsp_in.out_byte      = status.head.data[idx_ff];
      rsp_in.has_byte      = !status.head.marker;
      rsp_in.last_of_item  = last_k;
      rsp_in.end_of_string = last_k && status.head.last;

      rd_en    = load && last_k;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_k ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   // byte index stays inside the burst at the queue head
   assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> ({1'b0, idx_ff} < status.head.count))
      else $error("byte index past end of burst");

endmodule
